// ===== src/ldff_pkg.sv =====
// shared types, constants and the segment table of the led digit frame formatter
package ldff_pkg;

	// request and result field widths
	localparam int CMD_W      = 2;
	localparam int POS_W      = 3;
	localparam int VALUE_W    = 20;
	localparam int DCNT_W     = 3;
	localparam int DP_W       = 6;
	localparam int RAW_W      = 8;
	localparam int BYTE_W     = 8;
	localparam int DIGIT_W    = 4;

	// default digit count of the display
	localparam int MAX_DIGITS_DEF = 6;

	// job queue depth
	localparam int QUEUE_DEPTH = 2;

	// divide by ten through a reciprocal: q = (x * RECIP) >> RECIP_SHIFT
	localparam int RECIP_W     = 20;
	localparam logic [RECIP_W-1:0] RECIP = 20'hCCCCD;
	localparam int RECIP_SHIFT = 23;

	// controller bytes
	localparam logic [BYTE_W-1:0] ADDR_BASE  = 8'hC0;
	localparam logic [BYTE_W-1:0] DP_BIT     = 8'h80;
	localparam logic [BYTE_W-1:0] DATA_MODE  = 8'h40;
	localparam logic [BYTE_W-1:0] DISPLAY_ON = 8'h8F;
	localparam logic [DIGIT_W-1:0] DIGIT_EIGHT = 4'd8;

	typedef enum logic [CMD_W-1:0] {
		CMD_NUMBER = 2'd0,
		CMD_RAW    = 2'd1,
		CMD_INIT   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	// job fields that do not depend on the digit count
	typedef struct packed {
		cmd_t             cmd;
		logic [POS_W-1:0] pos;
		logic [DP_W-1:0]  dp;
		logic [RAW_W-1:0] raw;
	} job_hdr_t;

	// seven-segment pattern of one decimal digit
	function automatic logic [BYTE_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
		logic [BYTE_W-1:0] s;
		case (d)
			4'd0: s = 8'h3F;
			4'd1: s = 8'h06;
			4'd2: s = 8'h5B;
			4'd3: s = 8'h4F;
			4'd4: s = 8'h66;
			4'd5: s = 8'h6D;
			4'd6: s = 8'h7D;
			4'd7: s = 8'h07;
			4'd8: s = 8'h7F;
			4'd9: s = 8'h6F;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

// ===== src/ldff_req_if.sv =====
// request channel: valid, ready and the request fields
interface ldff_req_if import ldff_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [POS_W-1:0]   start_position;
	logic [VALUE_W-1:0] value;
	logic [DCNT_W-1:0]  digit_count;
	logic [DP_W-1:0]    dp_mask;
	logic [RAW_W-1:0]   raw_pattern;

	modport source (
		output valid, command, start_position, value, digit_count, dp_mask, raw_pattern,
		input  ready
	);
	modport sink (
		input  valid, command, start_position, value, digit_count, dp_mask, raw_pattern,
		output ready
	);
endinterface

// ===== src/ldff_byte_if.sv =====
// result channel: valid, ready and one frame byte with its markers
interface ldff_byte_if import ldff_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              frame_start;
	logic              frame_end;
	logic              last;

	modport source (
		output valid, data_byte, frame_start, frame_end, last,
		input  ready
	);
	modport sink (
		input  valid, data_byte, frame_start, frame_end, last,
		output ready
	);
endinterface

// ===== src/ldff_front.sv =====
// front end: takes requests, clamps the digit count and splits the value into digits
module ldff_front import ldff_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF,
	localparam int CNT_W  = $clog2(MAX_DIGITS + 1),
	localparam int DIGS_W = MAX_DIGITS * DIGIT_W
) (
	input  logic              clk,
	input  logic              arst_n,
	ldff_req_if.sink          req,
	output logic              push,
	input  logic              full,
	output job_hdr_t          push_hdr,
	output logic [CNT_W-1:0]  push_cnt,
	output logic [DIGS_W-1:0] push_digs
);

	logic                         busy_q;
	logic [CNT_W-1:0]             steps_q;
	job_hdr_t                     hdr_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [VALUE_W-1:0]           val_q;
	logic [DIGS_W-1:0]            digs_q;

	logic                         accept;
	logic                         take;
	logic                         step;
	logic [CNT_W-1:0]             ndig;
	logic [VALUE_W+RECIP_W-1:0]   prod;
	logic [VALUE_W+RECIP_W-1-RECIP_SHIFT:0] quot;
	logic [VALUE_W-1:0]           quot10;
	logic [VALUE_W-1:0]           rem;

	// handshake and work flags
	assign req.ready = !busy_q;
	assign accept    = req.valid && !busy_q;
	assign take      = accept && (cmd_t'(req.command) != CMD_NONE);
	assign step      = busy_q && (steps_q != '0);
	assign push      = busy_q && (steps_q == '0) && !full;

	// digit count held between two and the display width
	always_comb begin
		if (int'(req.digit_count) > MAX_DIGITS) begin
			ndig = CNT_W'(MAX_DIGITS);
		end else if (req.digit_count < DCNT_W'(2)) begin
			ndig = CNT_W'(2);
		end else begin
			ndig = CNT_W'(req.digit_count);
		end
	end

	// one divide-by-ten step: quotient by reciprocal, remainder by shift-add
	assign prod   = val_q * RECIP;
	assign quot   = prod[VALUE_W+RECIP_W-1:RECIP_SHIFT];
	assign quot10 = VALUE_W'({quot, 3'b000}) + VALUE_W'({quot, 1'b0});
	assign rem    = val_q - quot10;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			steps_q <= '0;
		end else if (take) begin
			busy_q  <= 1'b1;
			steps_q <= (cmd_t'(req.command) == CMD_NUMBER) ? ndig : '0;
		end else if (step) begin
			steps_q <= steps_q - CNT_W'(1);
		end else if (push) begin
			busy_q <= 1'b0;
		end
	end

	// job payload; the newest digit enters at the low end, so the leftmost ends lowest
	always_ff @(posedge clk) begin
		if (take) begin
			hdr_q.cmd <= cmd_t'(req.command);
			hdr_q.pos <= req.start_position;
			hdr_q.dp  <= req.dp_mask;
			hdr_q.raw <= req.raw_pattern;
			cnt_q     <= ndig;
			val_q     <= req.value;
			digs_q    <= '0;
		end else if (step) begin
			val_q  <= VALUE_W'(quot);
			digs_q <= {digs_q[DIGS_W-DIGIT_W-1:0], rem[DIGIT_W-1:0]};
		end
	end

	assign push_hdr  = hdr_q;
	assign push_cnt  = cnt_q;
	assign push_digs = digs_q;

endmodule

// ===== src/ldff_queue.sv =====
// short job queue between the front end and the byte sequencer
module ldff_queue import ldff_pkg::*; #(
	parameter int CNT_W  = 3,
	parameter int DIGS_W = 24,
	localparam int PTR_W = $clog2(QUEUE_DEPTH),
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  job_hdr_t          push_hdr,
	input  logic [CNT_W-1:0]  push_cnt,
	input  logic [DIGS_W-1:0] push_digs,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output job_hdr_t          pop_hdr,
	output logic [CNT_W-1:0]  pop_cnt,
	output logic [DIGS_W-1:0] pop_digs
);

	job_hdr_t          hdr_q  [QUEUE_DEPTH];
	logic [CNT_W-1:0]  cnt_q  [QUEUE_DEPTH];
	logic [DIGS_W-1:0] digs_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;

	assign full  = (fill_q == FILL_W'(QUEUE_DEPTH));
	assign empty = (fill_q == '0);

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			hdr_q[wr_ptr_q]  <= push_hdr;
			cnt_q[wr_ptr_q]  <= push_cnt;
			digs_q[wr_ptr_q] <= push_digs;
		end
	end

	assign pop_hdr  = hdr_q[rd_ptr_q];
	assign pop_cnt  = cnt_q[rd_ptr_q];
	assign pop_digs = digs_q[rd_ptr_q];

endmodule

// ===== src/ldff_back.sv =====
// back end: walks one job and emits its frame bytes through an output register
module ldff_back import ldff_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF,
	localparam int CNT_W  = $clog2(MAX_DIGITS + 1),
	localparam int DIGS_W = MAX_DIGITS * DIGIT_W,
	localparam int IDX_W  = $clog2(MAX_DIGITS + 3)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	output logic              pop,
	input  job_hdr_t          pop_hdr,
	input  logic [CNT_W-1:0]  pop_cnt,
	input  logic [DIGS_W-1:0] pop_digs,
	ldff_byte_if.source       rsp
);

	logic              busy_q;
	logic [IDX_W-1:0]  idx_q;
	job_hdr_t          hdr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIGS_W-1:0] digs_q;
	logic [DP_W-1:0]   dp_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_fs_q;
	logic              out_fe_q;
	logic              out_last_q;

	logic              advance;
	logic [BYTE_W-1:0] nxt_byte;
	logic              nxt_fs;
	logic              nxt_fe;
	logic              nxt_last;
	logic [BYTE_W-1:0] addr_byte;

	// a byte moves on when the output register is free or being drained
	assign advance   = busy_q && (!out_valid_q || rsp.ready);
	assign pop       = !empty && (!busy_q || (advance && nxt_last));
	assign addr_byte = ADDR_BASE | BYTE_W'(hdr_q.pos);

	// byte selection by command and position in the request
	always_comb begin
		nxt_byte = '0;
		nxt_fs   = 1'b0;
		nxt_fe   = 1'b0;
		nxt_last = 1'b0;
		case (hdr_q.cmd)
			CMD_NUMBER: begin
				if (idx_q == '0) begin
					nxt_byte = addr_byte;
					nxt_fs   = 1'b1;
				end else begin
					nxt_byte = seg_of(digs_q[DIGIT_W-1:0]) | (dp_q[0] ? DP_BIT : '0);
					nxt_fe   = (idx_q == IDX_W'(cnt_q));
					nxt_last = nxt_fe;
				end
			end
			CMD_RAW: begin
				if (idx_q == '0) begin
					nxt_byte = addr_byte;
					nxt_fs   = 1'b1;
				end else begin
					nxt_byte = hdr_q.raw | (hdr_q.dp[0] ? DP_BIT : '0);
					nxt_fe   = 1'b1;
					nxt_last = 1'b1;
				end
			end
			CMD_INIT: begin
				if (idx_q == '0) begin
					nxt_byte = DATA_MODE;
					nxt_fs   = 1'b1;
					nxt_fe   = 1'b1;
				end else if (idx_q == IDX_W'(1)) begin
					nxt_byte = ADDR_BASE;
					nxt_fs   = 1'b1;
				end else if (idx_q == IDX_W'(MAX_DIGITS + 2)) begin
					nxt_byte = DISPLAY_ON;
					nxt_fs   = 1'b1;
					nxt_fe   = 1'b1;
					nxt_last = 1'b1;
				end else begin
					nxt_byte = seg_of(DIGIT_EIGHT);
					nxt_fe   = (idx_q == IDX_W'(MAX_DIGITS + 1));
				end
			end
			default: begin
				nxt_last = 1'b1;
			end
		endcase
	end

	// sequencer and output register control; a new job wins over the step of the old one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (advance) begin
				idx_q <= idx_q + IDX_W'(1);
				if (nxt_last) begin
					busy_q <= 1'b0;
				end
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// job payload and output byte
	always_ff @(posedge clk) begin
		if (pop) begin
			hdr_q  <= pop_hdr;
			cnt_q  <= pop_cnt;
			digs_q <= pop_digs;
			dp_q   <= pop_hdr.dp;
		end else if (advance && (idx_q != '0)) begin
			digs_q <= digs_q >> DIGIT_W;
			dp_q   <= dp_q >> 1;
		end
		if (advance) begin
			out_byte_q <= nxt_byte;
			out_fs_q   <= nxt_fs;
			out_fe_q   <= nxt_fe;
			out_last_q <= nxt_last;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.data_byte   = out_byte_q;
	assign rsp.frame_start = out_fs_q;
	assign rsp.frame_end   = out_fe_q;
	assign rsp.last        = out_last_q;

endmodule

// ===== src/led_digit_frame_formatter.sv =====
// Frame builder for a seven-segment LED display controller.
// Number request: accepted, then one divide-by-ten step per digit in the front
// end (clamped digit count, 2 to MAX_DIGITS), then pushed into the job queue for
// the back end. Back end sends one byte per cycle while the receiver is ready: digit
// count+1 bytes per number, 2 per raw, MAX_DIGITS+3 per init. Front end takes no
// new request until the last job is pushed; the push waits while the queue is full.
// Reset (arst_n low) empties the job queue and the output register at once.
module led_digit_frame_formatter import ldff_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ldff_req_if.sink    req,
	ldff_byte_if.source rsp
);

	localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
	localparam int DIGS_W = MAX_DIGITS * DIGIT_W;

	logic              q_push;
	logic              q_full;
	logic              q_pop;
	logic              q_empty;
	job_hdr_t          in_hdr;
	logic [CNT_W-1:0]  in_cnt;
	logic [DIGS_W-1:0] in_digs;
	job_hdr_t          out_hdr;
	logic [CNT_W-1:0]  out_cnt;
	logic [DIGS_W-1:0] out_digs;

	// request intake and digit split
	ldff_front #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.push     (q_push),
		.full     (q_full),
		.push_hdr (in_hdr),
		.push_cnt (in_cnt),
		.push_digs(in_digs)
	);

	// job queue
	ldff_queue #(
		.CNT_W (CNT_W),
		.DIGS_W(DIGS_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_hdr (in_hdr),
		.push_cnt (in_cnt),
		.push_digs(in_digs),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.pop_hdr  (out_hdr),
		.pop_cnt  (out_cnt),
		.pop_digs (out_digs)
	);

	// byte sequencer
	ldff_back #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.empty   (q_empty),
		.pop     (q_pop),
		.pop_hdr (out_hdr),
		.pop_cnt (out_cnt),
		.pop_digs(out_digs),
		.rsp     (rsp)
	);

	// the queue is never written while full nor read while empty
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("job queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("job queue read while empty");

	// the final byte of a request always closes a frame
	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.last) |-> rsp.frame_end)
		else $error("last byte without frame end");

	// an open frame always starts with an address byte
	a_open_frame_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.frame_start && !rsp.frame_end) |-> (rsp.data_byte[7:6] == 2'b11))
		else $error("frame opened by a non-address byte");

endmodule
